// ----- rtl/core/csvq_pkg.sv -----
// Shared types, character codes, field numbers and constants of the quote line parser.
// No dependencies; compile first.
`default_nettype none

package csvq_pkg;

  // Counter and datapath widths
  localparam int CNT_W          = 5;   // holds the ticker length up to its largest limit (24)
  localparam int TICKER_MAX_DEF = 20;
  localparam int CHUNK_MAX      = 3;   // 8-character ticker chunks per line
  localparam int SCALE_W        = 27;  // holds 10^8
  localparam int PROD_W         = 32 + SCALE_W;
  localparam int VALUE_W        = 64;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_PRICE_FRAC = 1'b0;
  localparam logic [3:0] PRICE_FRAC_RST = 4'd4;
  localparam logic [3:0] PRICE_FRAC_MAX = 4'd8;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Field numbers along the line
  localparam logic [3:0] FIELD_TICKER = 4'd0;
  localparam logic [3:0] FIELD_PERIOD = 4'd1;
  localparam logic [3:0] FIELD_DATE   = 4'd2;
  localparam logic [3:0] FIELD_TIME   = 4'd3;
  localparam logic [3:0] FIELD_OPEN   = 4'd4;
  localparam logic [3:0] FIELD_CLOSE  = 4'd7;
  localparam logic [3:0] FIELD_VOLUME = 4'd8;
  localparam logic [3:0] FIELD_OI     = 4'd9;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_TICKER_LONG = 2'd1,
    ERR_PERIOD_LONG = 2'd2,
    ERR_LINE_SHORT  = 2'd3
  } csvq_err_t;

  // Everything of a result but its value
  typedef struct packed {
    logic [3:0] field_index;
    logic [1:0] chunk_index;
    csvq_err_t  error_code;
    logic       last_of_run;
    logic       end_of_record;
  } csvq_tag_t;

  function automatic logic [SCALE_W-1:0] pow10_scale(input logic [3:0] k);
    logic [SCALE_W-1:0] s;
    case (k)
      4'd0:    s = SCALE_W'(1);
      4'd1:    s = SCALE_W'(10);
      4'd2:    s = SCALE_W'(100);
      4'd3:    s = SCALE_W'(1000);
      4'd4:    s = SCALE_W'(10000);
      4'd5:    s = SCALE_W'(100000);
      4'd6:    s = SCALE_W'(1000000);
      4'd7:    s = SCALE_W'(10000000);
      4'd8:    s = SCALE_W'(100000000);
      default: s = SCALE_W'(1);
    endcase
    return s;
  endfunction

  // acc*10 + byte - '0', wrapping at 64 bits
  function automatic logic [VALUE_W-1:0] add_digit(input logic [VALUE_W-1:0] acc,
                                                   input logic [7:0] b);
    return (acc << 3) + (acc << 1) + VALUE_W'(b) - VALUE_W'(CH_ZERO);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/csvq_stream_if.sv -----
// Valid/ready stream interfaces: text bytes in, parsed fields out.
// No dependencies.
`default_nettype none

interface csvq_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface csvq_field_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_index;
  logic [1:0]  chunk_index;
  logic [63:0] field_value;
  logic [1:0]  error_code;
  logic        last_of_run;
  logic        end_of_record;

  modport source (output valid, output field_index, output chunk_index, output field_value,
                  output error_code, output last_of_run, output end_of_record, input ready);
  modport sink   (input valid, input field_index, input chunk_index, input field_value,
                  input error_code, input last_of_run, input end_of_record, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/csvq_scaler.sv -----
// Two-stage result pipeline: split 64x27 scaling multiply, then sum into the output register.
// Depends on csvq_pkg and csvq_field_if.
`default_nettype none

module csvq_scaler (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load_valid,
  output logic                             load_ready,
  input  wire csvq_pkg::csvq_tag_t         load_tag,
  input  wire logic [63:0]                 load_value,
  input  wire logic [csvq_pkg::SCALE_W-1:0] load_scale,
  csvq_field_if.source                     field_stream
);
  import csvq_pkg::*;

  logic              m_valid;
  csvq_tag_t         m_tag;
  logic [PROD_W-1:0] m_lo;
  logic [31:0]       m_hi;
  logic [PROD_W-1:0] prod_lo;
  logic [PROD_W-1:0] prod_hi;
  logic              o_adv;

  // Low 64 bits of value*scale from two 32-bit halves
  assign prod_lo = PROD_W'(load_value[31:0]) * PROD_W'(load_scale);
  assign prod_hi = PROD_W'(load_value[63:32]) * PROD_W'(load_scale);

  assign o_adv      = !field_stream.valid || field_stream.ready;
  assign load_ready = !m_valid || o_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load_ready) begin
      m_valid <= load_valid;
    end
    if (load_ready && load_valid) begin
      m_tag <= load_tag;
      m_lo  <= prod_lo;
      m_hi  <= prod_hi[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_stream.valid <= 1'b0;
    end else if (o_adv) begin
      field_stream.valid <= m_valid;
    end
    if (o_adv && m_valid) begin
      field_stream.field_index   <= m_tag.field_index;
      field_stream.chunk_index   <= m_tag.chunk_index;
      field_stream.error_code    <= m_tag.error_code;
      field_stream.last_of_run   <= m_tag.last_of_run;
      field_stream.end_of_record <= m_tag.end_of_record;
      field_stream.field_value   <= {{(VALUE_W-PROD_W){1'b0}}, m_lo} + {m_hi, 32'h0};
    end
  end

  a_load_lands: assert property (@(posedge clk) disable iff (rst)
    load_valid && load_ready |=> m_valid)
    else $error("accepted result did not reach the multiply stage");

  a_mul_holds: assert property (@(posedge clk) disable iff (rst)
    m_valid && !o_adv |=> m_valid && $stable(m_tag) && $stable(m_lo))
    else $error("stalled multiply stage lost or changed its result");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    field_stream.valid && !field_stream.ready |=>
      field_stream.valid && $stable(field_stream.field_value))
    else $error("stalled output lost or changed its field");

endmodule

`default_nettype wire

// ----- rtl/core/csv_quote_record_parser_unit.sv -----
// Top level of the quote line parser: APB register, per-byte field parser, ticker chunker.
// Depends on csvq_pkg, csvq_stream_if and csvq_scaler.
`default_nettype none

// Parses comma-separated quote lines (ticker, period, date, time, open, high, low, close,
// volume, open interest) one text byte per cycle on byte_stream and delivers each finished
// field as a binary value on field_stream. A byte is taken every cycle while the result path
// has room; the only other hold comes from a comma that closes a ticker longer than eight
// characters, which holds byte_stream while each additional 8-character chunk (at most two)
// goes out. A result reaches field_stream through the split 64x27 scaling multiplier stage,
// which pads prices to price_fraction_digits fraction digits, then the output register.
// Errors (ticker too long, period too long, line ended early) produce one result with
// end_of_record set; after the first two the rest of the line is dropped up to the next
// newline or NUL. price_fraction_digits (byte address 0, reset 4, values above 8 act as 8)
// should only be written while no result is outstanding.
module csv_quote_record_parser_unit #(
  parameter int TICKER_MAX = csvq_pkg::TICKER_MAX_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [csvq_pkg::PADDR_W-1:0] paddr,
  input  wire logic [csvq_pkg::PDATA_W-1:0] pwdata,
  output logic      [csvq_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  csvq_byte_if.sink                         byte_stream,
  csvq_field_if.source                      field_stream
);
  import csvq_pkg::*;

  // Kind of value handed to the result pipeline
  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_ACCUM = 2'd1,
    SRC_CHUNK = 2'd2
  } src_t;

  // ---------------------------------------------------------------- configuration register
  logic [3:0] price_frac;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1:2] == REG_PRICE_FRAC);
  assign prdata    = (paddr[PADDR_W-1:2] == REG_PRICE_FRAC) ?
                     {{(PDATA_W-4){1'b0}}, price_frac} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      price_frac <= PRICE_FRAC_RST;
    end else if (cfg_write) begin
      price_frac <= pwdata[3:0];
    end
  end

  // ---------------------------------------------------------------- parser state
  logic [3:0]         field_pos,  field_pos_next;
  logic [CNT_W-1:0]   char_count, char_count_next;
  logic [VALUE_W-1:0] accum,      accum_next;
  logic [3:0]         frac_seen,  frac_seen_next;
  logic               in_frac,    in_frac_next;
  logic               skip_rest,  skip_rest_next;
  logic               discard,    discard_next;
  logic [7:0]         ticker_store [TICKER_MAX];

  // Pending ticker chunks after the first
  logic               chunk_pend;
  logic [1:0]         pend_chunk;
  logic [1:0]         pend_last;
  logic [CNT_W-1:0]   tick_len;

  logic               byte_fire;
  logic               load_ready;
  logic               line_end;
  logic               is_comma;
  logic [VALUE_W-1:0] digit_sum;
  logic [CNT_W-1:0]   cc_inc;
  logic [3:0]         frac_lim;
  logic [SCALE_W-1:0] price_scale;
  logic [CNT_W:0]     chunk_round;
  logic [1:0]         chunk_n;

  logic               emit;
  logic               emit_scaled;
  src_t               emit_src;
  csvq_tag_t          emit_tag;
  logic               store_we;
  logic               do_next_line;
  logic               do_clear_field;

  logic [VALUE_W-1:0] chunk_word [CHUNK_MAX];
  logic [CNT_W-1:0]   len_sel;
  logic [1:0]         chunk_sel;
  logic [VALUE_W-1:0] chunk_value;

  logic               load_valid;
  csvq_tag_t          load_tag;
  logic [VALUE_W-1:0] load_value;
  logic [SCALE_W-1:0] load_scale;

  // Hold input while later ticker chunks go out
  assign byte_stream.ready = load_ready && !chunk_pend;
  assign byte_fire         = byte_stream.valid && byte_stream.ready;

  assign line_end  = (byte_stream.text_byte == CH_LF) || (byte_stream.text_byte == CH_NUL);
  assign is_comma  = (byte_stream.text_byte == CH_COMMA);
  assign digit_sum = add_digit(accum, byte_stream.text_byte);
  assign cc_inc    = char_count + CNT_W'(1);

  assign frac_lim    = (price_frac > PRICE_FRAC_MAX) ? PRICE_FRAC_MAX : price_frac;
  assign price_scale = (frac_seen < frac_lim) ? pow10_scale(frac_lim - frac_seen) : SCALE_W'(1);

  // Chunks in the ticker: ceil(len/8), at least one, at most three
  assign chunk_round = {1'b0, char_count} + (CNT_W+1)'(7);
  always_comb begin
    if (chunk_round[CNT_W:3] == '0) begin
      chunk_n = 2'd1;
    end else if (chunk_round[CNT_W:3] > (CNT_W-2)'(CHUNK_MAX)) begin
      chunk_n = 2'(CHUNK_MAX);
    end else begin
      chunk_n = chunk_round[4:3];
    end
  end

  // ---------------------------------------------------------------- per-byte parse
  always_comb begin
    field_pos_next  = field_pos;
    char_count_next = char_count;
    accum_next      = accum;
    frac_seen_next  = frac_seen;
    in_frac_next    = in_frac;
    skip_rest_next  = skip_rest;
    discard_next    = discard;
    store_we        = 1'b0;
    do_next_line    = 1'b0;
    do_clear_field  = 1'b0;
    emit            = 1'b0;
    emit_scaled     = 1'b0;
    emit_src        = SRC_ZERO;
    emit_tag        = '{field_index: field_pos, chunk_index: 2'd0, error_code: ERR_NONE,
                        last_of_run: 1'b1, end_of_record: 1'b0};

    if (byte_fire) begin
      if (discard) begin
        // Drop bytes until the line ends
        if (line_end) begin
          discard_next = 1'b0;
          do_next_line = 1'b1;
        end
      end else if (field_pos > FIELD_OI) begin
        do_next_line = 1'b1;
      end else if (field_pos == FIELD_TICKER && char_count == '0 &&
                   (line_end || byte_stream.text_byte == CH_CR)) begin
        // Empty line: ignore
      end else if (field_pos == FIELD_OI) begin
        if (line_end || byte_stream.text_byte == CH_CR || is_comma) begin
          emit                   = 1'b1;
          emit_src               = SRC_ACCUM;
          emit_tag.end_of_record = 1'b1;
          do_next_line           = 1'b1;
          discard_next           = !line_end;
        end else if (!skip_rest) begin
          if (byte_stream.text_byte == CH_DOT) begin
            skip_rest_next = 1'b1;
          end else begin
            accum_next = digit_sum;
          end
        end
      end else if (line_end) begin
        emit                   = 1'b1;
        emit_tag.error_code    = ERR_LINE_SHORT;
        emit_tag.end_of_record = 1'b1;
        do_next_line           = 1'b1;
        discard_next           = 1'b0;
      end else if (is_comma) begin
        // Field done: emit it and advance
        emit           = 1'b1;
        emit_src       = SRC_ACCUM;
        do_clear_field = 1'b1;
        field_pos_next = field_pos + 4'd1;
        if (field_pos == FIELD_TICKER) begin
          emit_src             = SRC_CHUNK;
          emit_tag.last_of_run = (chunk_n == 2'd1);
        end else if (field_pos >= FIELD_OPEN && field_pos <= FIELD_CLOSE) begin
          emit_scaled = 1'b1;
        end
      end else begin
        unique case (field_pos)
          FIELD_TICKER: begin
            store_we        = (char_count < CNT_W'(TICKER_MAX));
            char_count_next = cc_inc;
            if (cc_inc >= CNT_W'(TICKER_MAX)) begin
              emit                   = 1'b1;
              emit_tag.error_code    = ERR_TICKER_LONG;
              emit_tag.end_of_record = 1'b1;
              do_next_line           = 1'b1;
              discard_next           = 1'b1;
            end
          end
          FIELD_PERIOD: begin
            accum_next      = VALUE_W'(byte_stream.text_byte);
            char_count_next = cc_inc;
            if (cc_inc >= CNT_W'(2)) begin
              emit                   = 1'b1;
              emit_tag.error_code    = ERR_PERIOD_LONG;
              emit_tag.end_of_record = 1'b1;
              do_next_line           = 1'b1;
              discard_next           = 1'b1;
            end
          end
          FIELD_DATE, FIELD_TIME: begin
            accum_next = digit_sum;
          end
          FIELD_VOLUME: begin
            if (!skip_rest) begin
              if (byte_stream.text_byte == CH_DOT) begin
                skip_rest_next = 1'b1;
              end else begin
                accum_next = digit_sum;
              end
            end
          end
          default: begin
            // Prices: integer part, then up to frac_lim fraction digits
            if (!in_frac) begin
              if (byte_stream.text_byte == CH_DOT) begin
                in_frac_next = 1'b1;
              end else begin
                accum_next = digit_sum;
              end
            end else if (frac_seen < frac_lim) begin
              accum_next     = digit_sum;
              frac_seen_next = frac_seen + 4'd1;
            end
          end
        endcase
      end

      if (do_clear_field || do_next_line) begin
        char_count_next = '0;
        accum_next      = '0;
        frac_seen_next  = '0;
        in_frac_next    = 1'b0;
        skip_rest_next  = 1'b0;
      end
      if (do_next_line) begin
        field_pos_next = FIELD_TICKER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_pos  <= FIELD_TICKER;
      char_count <= '0;
      accum      <= '0;
      frac_seen  <= '0;
      in_frac    <= 1'b0;
      skip_rest  <= 1'b0;
      discard    <= 1'b0;
    end else begin
      field_pos  <= field_pos_next;
      char_count <= char_count_next;
      accum      <= accum_next;
      frac_seen  <= frac_seen_next;
      in_frac    <= in_frac_next;
      skip_rest  <= skip_rest_next;
      discard    <= discard_next;
    end
  end

  // Ticker characters; entries past the current length are never read
  always_ff @(posedge clk) begin
    for (int i = 0; i < TICKER_MAX; i++) begin
      if (store_we && char_count == CNT_W'(i)) begin
        ticker_store[i] <= byte_stream.text_byte;
      end
    end
  end

  // ---------------------------------------------------------------- ticker chunks
  assign len_sel   = chunk_pend ? tick_len : char_count;
  assign chunk_sel = chunk_pend ? pend_chunk : 2'd0;

  // Pack each chunk little-endian, zeros past the ticker's end
  always_comb begin
    for (int c = 0; c < CHUNK_MAX; c++) begin
      chunk_word[c] = '0;
      for (int i = 0; i < 8; i++) begin
        if (c * 8 + i < TICKER_MAX) begin
          if (CNT_W'(c * 8 + i) < len_sel) begin
            chunk_word[c][8*i +: 8] = ticker_store[c * 8 + i];
          end
        end
      end
    end
  end

  always_comb begin
    if (chunk_sel == 2'd2) begin
      chunk_value = chunk_word[2];
    end else if (chunk_sel == 2'd1) begin
      chunk_value = chunk_word[1];
    end else begin
      chunk_value = chunk_word[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_pend <= 1'b0;
      pend_chunk <= 2'd0;
      pend_last  <= 2'd0;
    end else if (chunk_pend) begin
      if (load_ready) begin
        if (pend_chunk == pend_last) begin
          chunk_pend <= 1'b0;
        end else begin
          pend_chunk <= pend_chunk + 2'd1;
        end
      end
    end else if (emit && emit_src == SRC_CHUNK && chunk_n > 2'd1) begin
      chunk_pend <= 1'b1;
      pend_chunk <= 2'd1;
      pend_last  <= chunk_n - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!chunk_pend && emit && emit_src == SRC_CHUNK) begin
      tick_len <= char_count;
    end
  end

  // ---------------------------------------------------------------- result pipeline
  always_comb begin
    if (chunk_pend) begin
      load_valid = 1'b1;
      load_tag   = '{field_index: FIELD_TICKER, chunk_index: pend_chunk, error_code: ERR_NONE,
                     last_of_run: (pend_chunk == pend_last), end_of_record: 1'b0};
      load_value = chunk_value;
      load_scale = SCALE_W'(1);
    end else begin
      load_valid = emit;
      load_tag   = emit_tag;
      load_scale = emit_scaled ? price_scale : SCALE_W'(1);
      unique case (emit_src)
        SRC_ACCUM: load_value = accum;
        SRC_CHUNK: load_value = chunk_value;
        default:   load_value = '0;
      endcase
    end
  end

  csvq_scaler u_scaler (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (load_valid),
    .load_ready   (load_ready),
    .load_tag     (load_tag),
    .load_value   (load_value),
    .load_scale   (load_scale),
    .field_stream (field_stream)
  );

  // ---------------------------------------------------------------- checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    field_pos <= FIELD_OI)
    else $error("field position ran past open interest");

  a_ticker_len: assert property (@(posedge clk) disable iff (rst)
    char_count < CNT_W'(TICKER_MAX))
    else $error("ticker length reached its limit without an error");

  a_chunk_seq: assert property (@(posedge clk) disable iff (rst)
    chunk_pend |-> pend_chunk <= pend_last && pend_last < 2'(CHUNK_MAX) && pend_chunk != 2'd0)
    else $error("ticker chunk sequencer out of range");

  a_discard_ends: assert property (@(posedge clk) disable iff (rst)
    byte_fire && discard && line_end |=>
      !discard && field_pos == FIELD_TICKER && char_count == '0)
    else $error("line end did not leave discard mode with a fresh line");

endmodule

`default_nettype wire
